@@ design/jmse_pkg.sv @@
package jmse_pkg;

    // Item kinds on the input stream.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Command codes carried by a start word.
    localparam logic [1:0] CMD_TAP_RESET = 2'd0;
    localparam logic [1:0] CMD_TMS_SEQ   = 2'd1;
    localparam logic [1:0] CMD_SCAN      = 2'd2;
    localparam logic [1:0] CMD_SCAN_EXIT = 2'd3;

    // TMS-high clocks of a TAP reset, and bits in a full byte.
    localparam logic [3:0] RESET_CLOCKS = 4'd5;
    localparam logic [3:0] BYTE_BITS    = 4'd8;

    // One input word, unpacked.
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] byte_index;
        logic [7:0] byte_value;
        logic [1:0] command;
        logic [6:0] length_bytes;
        logic [9:0] bit_count;
        logic       tdo_in;
    } t_item;

    // One result word, unpacked.
    typedef struct packed {
        logic       tck_out;
        logic       tms_out;
        logic       tdi_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } t_result;

endpackage

@@ design/jmse_engine.sv @@
module jmse_engine #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_fire,
    input  jmse_pkg::t_item   i_item,
    input  logic [5:0]        i_rd_index,
    output jmse_pkg::t_result o_result
);

    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_RESET,
        MODE_TO_IDLE,
        MODE_TMS,
        MODE_SCAN
    } t_mode;

    // Sequencer state.
    t_mode       r_mode, n_mode;
    logic [6:0]  r_byte_pos, n_byte_pos;
    logic [3:0]  r_bit_pos, n_bit_pos;
    logic [7:0]  r_shift, n_shift;
    logic        r_low, n_low;
    logic [15:0] r_phase, n_phase;
    logic        r_cap, n_cap;
    logic        r_tms_end, n_tms_end;
    logic [6:0]  r_len, n_len;
    logic [2:0]  r_last_bits, n_last_bits;
    logic [2:0]  r_pins, n_pins;
    logic [7:0]  r_in_acc, n_in_acc;
    logic [15:0] r_half;

    // Buffers and their read ports.
    logic [7:0]        r_out_mem [BUFFER_BYTES];
    logic [7:0]        r_in_mem  [BUFFER_BYTES];
    logic [7:0]        r_out_q, r_in_q;
    logic              r_out_fwd, r_in_fwd;
    logic [7:0]        r_out_fwd_data, r_in_fwd_data;
    logic [7:0]        out_rd, in_rd;

    logic              out_we, in_we;
    logic [ADDR_W-1:0] out_waddr, out_raddr, in_waddr, in_raddr;
    logic [7:0]        in_wdata;

    // Tick helpers.
    logic [12:0] idx_wide, pos_wide, next_pos_wide, rd_idx_wide;
    logic        idx_ok;
    logic        shifting, last_byte, clk_done;
    logic [3:0]  nbits;
    logic [15:0] hp;
    logic [7:0]  cur_shift, acc;
    logic        cap_now, tms, tdi, tck;
    logic [2:0]  pins;
    logic        done;
    logic [7:0]  rd;

    assign idx_wide      = 13'(i_item.byte_index);
    assign idx_ok        = idx_wide < 13'(BUFFER_BYTES);
    assign pos_wide      = 13'(r_byte_pos);
    assign next_pos_wide = 13'(n_byte_pos);
    assign rd_idx_wide   = 13'(i_rd_index);
    assign out_waddr     = idx_wide[ADDR_W-1:0];
    assign out_raddr     = next_pos_wide[ADDR_W-1:0];
    assign in_waddr      = pos_wide[ADDR_W-1:0];
    assign in_raddr      = rd_idx_wide[ADDR_W-1:0];
    assign out_we        = i_fire && (i_item.kind == jmse_pkg::KIND_LOAD) && idx_ok;

    assign out_rd = r_out_fwd ? r_out_fwd_data : r_out_q;
    assign in_rd  = r_in_fwd ? r_in_fwd_data : r_in_q;
    assign hp     = (r_half == 16'd0) ? 16'd1 : r_half;

    // Bits of the current byte; the final byte may be partial.
    assign shifting  = (r_mode == MODE_TMS) || (r_mode == MODE_SCAN);
    assign last_byte = (r_byte_pos + 7'd1) == r_len;
    assign nbits     = (last_byte && r_last_bits != 3'd0) ? {1'b0, r_last_bits}
                                                          : jmse_pkg::BYTE_BITS;

    // Next state and result for the word in the input register.
    always_comb begin
        n_mode      = r_mode;
        n_byte_pos  = r_byte_pos;
        n_bit_pos   = r_bit_pos;
        n_shift     = r_shift;
        n_low       = r_low;
        n_phase     = r_phase;
        n_cap       = r_cap;
        n_tms_end   = r_tms_end;
        n_len       = r_len;
        n_last_bits = r_last_bits;
        n_pins      = r_pins;
        n_in_acc    = r_in_acc;
        in_we       = 1'b0;
        in_wdata    = 8'd0;
        pins        = r_pins;
        done        = 1'b0;
        rd          = 8'd0;
        cur_shift   = r_shift;
        acc         = r_in_acc;
        cap_now     = r_cap;
        tms         = 1'b0;
        tdi         = 1'b0;
        tck         = 1'b0;
        clk_done    = 1'b0;

        if (i_fire) begin
            case (i_item.kind)
                jmse_pkg::KIND_TICK: begin
                    if (r_mode != MODE_IDLE) begin
                        if (shifting && r_byte_pos >= r_len) begin
                            // Nothing left to shift: complete with no clock.
                            pins       = 3'd0;
                            done       = 1'b1;
                            n_mode     = MODE_IDLE;
                            n_pins     = 3'd0;
                            n_byte_pos = 7'd0;
                            n_bit_pos  = 4'd0;
                            n_low      = 1'b1;
                            n_phase    = 16'd0;
                        end else begin
                            // A byte is latched as its first clock begins.
                            if (shifting && r_low && r_phase == 16'd0 &&
                                r_bit_pos == 4'd0) begin
                                cur_shift = out_rd;
                                if (r_mode == MODE_SCAN) begin
                                    acc      = 8'd0;
                                    in_we    = 1'b1;
                                    in_wdata = 8'd0;
                                end
                            end

                            // Pin levels of this tick.
                            if (r_mode == MODE_RESET) begin
                                tms = 1'b1;
                            end else if (r_mode == MODE_TMS) begin
                                tms = cur_shift[0];
                            end else if (r_mode == MODE_SCAN) begin
                                tdi = cur_shift[0];
                                tms = r_tms_end && last_byte &&
                                      ((r_bit_pos + 4'd1) == nbits);
                            end

                            // Clock phase counter; TDO sampled on the first high tick.
                            if (r_low) begin
                                tck = 1'b0;
                                if (r_phase >= hp) begin
                                    n_low   = 1'b0;
                                    n_phase = 16'd0;
                                end else begin
                                    n_phase = r_phase + 16'd1;
                                end
                            end else begin
                                tck = 1'b1;
                                if (r_phase == 16'd0) begin
                                    cap_now = i_item.tdo_in;
                                end
                                n_phase  = r_phase + 16'd1;
                                clk_done = n_phase >= hp;
                            end

                            pins     = {tdi, tms, tck};
                            n_pins   = pins;
                            n_cap    = cap_now;
                            n_shift  = cur_shift;
                            n_in_acc = acc;

                            // End of one TCK clock.
                            if (clk_done) begin
                                n_low   = 1'b1;
                                n_phase = 16'd0;
                                case (r_mode)
                                    MODE_RESET: begin
                                        if ((r_bit_pos + 4'd1) >= jmse_pkg::RESET_CLOCKS) begin
                                            n_bit_pos = 4'd0;
                                            n_mode    = MODE_TO_IDLE;
                                        end else begin
                                            n_bit_pos = r_bit_pos + 4'd1;
                                        end
                                    end
                                    MODE_TO_IDLE: begin
                                        done       = 1'b1;
                                        n_mode     = MODE_IDLE;
                                        n_pins     = 3'd0;
                                        n_byte_pos = 7'd0;
                                        n_bit_pos  = 4'd0;
                                    end
                                    MODE_TMS, MODE_SCAN: begin
                                        if (r_mode == MODE_SCAN) begin
                                            acc = acc | (8'(cap_now) << r_bit_pos[2:0]);
                                            in_we    = 1'b1;
                                            in_wdata = acc;
                                            n_in_acc = acc;
                                        end
                                        n_shift = {1'b0, cur_shift[7:1]};
                                        if ((r_bit_pos + 4'd1) >= nbits) begin
                                            n_bit_pos  = 4'd0;
                                            n_byte_pos = r_byte_pos + 7'd1;
                                            if ((r_byte_pos + 7'd1) >= r_len) begin
                                                done       = 1'b1;
                                                n_mode     = MODE_IDLE;
                                                n_pins     = 3'd0;
                                                n_byte_pos = 7'd0;
                                            end
                                        end else begin
                                            n_bit_pos = r_bit_pos + 4'd1;
                                        end
                                    end
                                    default: begin
                                        n_mode = MODE_IDLE;
                                    end
                                endcase
                            end
                        end
                    end
                end
                jmse_pkg::KIND_START: begin
                    if (r_mode == MODE_IDLE) begin
                        n_len = (13'(i_item.length_bytes) > 13'(BUFFER_BYTES))
                              ? 7'(BUFFER_BYTES) : i_item.length_bytes;
                        n_last_bits = i_item.bit_count[2:0];
                        n_byte_pos  = 7'd0;
                        n_bit_pos   = 4'd0;
                        n_low       = 1'b1;
                        n_phase     = 16'd0;
                        n_tms_end   = i_item.command == jmse_pkg::CMD_SCAN_EXIT;
                        case (i_item.command)
                            jmse_pkg::CMD_TAP_RESET: n_mode = MODE_RESET;
                            jmse_pkg::CMD_TMS_SEQ:   n_mode = MODE_TMS;
                            default:                 n_mode = MODE_SCAN;
                        endcase
                    end
                end
                jmse_pkg::KIND_READ: begin
                    if (idx_ok) begin
                        rd = in_rd;
                    end
                end
                default: begin
                    // Loads only touch the outbound buffer.
                end
            endcase
        end
    end

    assign o_result = '{
        tck_out:   pins[0],
        tms_out:   pins[1],
        tdi_out:   pins[2],
        busy_res:  n_mode != MODE_IDLE,
        done_res:  done,
        read_byte: rd
    };

    // Sequencer registers and the period register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_byte_pos  <= 7'd0;
            r_bit_pos   <= 4'd0;
            r_shift     <= 8'd0;
            r_low       <= 1'b1;
            r_phase     <= 16'd0;
            r_cap       <= 1'b0;
            r_tms_end   <= 1'b0;
            r_len       <= 7'd0;
            r_last_bits <= 3'd0;
            r_pins      <= 3'd0;
            r_in_acc    <= 8'd0;
            r_half      <= 16'd4;
        end else begin
            r_mode      <= n_mode;
            r_byte_pos  <= n_byte_pos;
            r_bit_pos   <= n_bit_pos;
            r_shift     <= n_shift;
            r_low       <= n_low;
            r_phase     <= n_phase;
            r_cap       <= n_cap;
            r_tms_end   <= n_tms_end;
            r_len       <= n_len;
            r_last_bits <= n_last_bits;
            r_pins      <= n_pins;
            r_in_acc    <= n_in_acc;
            if (i_cfg_wr_en) begin
                r_half <= i_cfg_wr_data;
            end
        end
    end

    // Outbound buffer: read ahead at the next byte position, with a bypass
    // for a load that lands on the address being read.
    always_ff @(posedge i_clk) begin
        if (out_we) begin
            r_out_mem[out_waddr] <= i_item.byte_value;
        end
        r_out_q        <= r_out_mem[out_raddr];
        r_out_fwd      <= out_we && (out_waddr == out_raddr);
        r_out_fwd_data <= i_item.byte_value;
    end

    // Inbound buffer: read at the index of the word entering the pipeline,
    // with a bypass for a capture written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (in_we) begin
            r_in_mem[in_waddr] <= in_wdata;
        end
        r_in_q        <= r_in_mem[in_raddr];
        r_in_fwd      <= in_we && (in_waddr == in_raddr);
        r_in_fwd_data <= in_wdata;
    end

endmodule

@@ design/jtag_master_shift_engine_core.sv @@
// Each word passes through the input register and then the result register.
// One word per cycle unless stalled; each tick word moves the TCK generator one step.
// The input register and the result register each hold one word, so input is
// taken while a finished result still waits at the output.
// Reset (i_rst_n low, synchronous) idles the sequencer, drives all pins low and
// sets half_period to 4; the byte buffers are not cleared.
module jtag_master_shift_engine_core #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,   // half_period
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_index[5:0], byte_value[13:6], command[15:14], length_bytes[22:16],
    // bit_count[32:23], tdo_in[33], zero fill[39:34]
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,    // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tck_out[0], tms_out[1], tdi_out[2], busy_res[3], done_res[4],
    // read_byte[12:5], zero fill[15:13]
    output logic [15:0] m_axis_tdata
);

    logic              r_in_valid;
    jmse_pkg::t_item   r_in;
    logic              r_out_valid;
    jmse_pkg::t_result r_out;

    logic              fire, accept;
    jmse_pkg::t_item   in_item;
    jmse_pkg::t_result step_result;
    logic [5:0]        rd_index;

    // Handshake: the input register moves on whenever the result register frees up.
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_item = '{
        kind:         s_axis_tuser,
        byte_index:   s_axis_tdata[5:0],
        byte_value:   s_axis_tdata[13:6],
        command:      s_axis_tdata[15:14],
        length_bytes: s_axis_tdata[22:16],
        bit_count:    s_axis_tdata[32:23],
        tdo_in:       s_axis_tdata[33]
    };

    // Inbound buffer read address follows the word that will sit in the input register.
    assign rd_index = accept ? in_item.byte_index : r_in.byte_index;

    jmse_engine #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_item        (r_in),
        .i_rd_index    (rd_index),
        .o_result      (step_result)
    );

    // Valid flags of the two pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= in_item;
        end
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.read_byte, r_out.done_res, r_out.busy_res,
                            r_out.tdi_out, r_out.tms_out, r_out.tck_out};

endmodule

@@ design/jmse_checker.sv @@
module jmse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Pins are only driven while a command runs or on its completion word.
    a_pins_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != 3'd0) |-> m_axis_tdata[3] || m_axis_tdata[4])
        else $error("pins active with no command in progress");

    // A completing word never reports busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
        else $error("done and busy reported together");

    // An accepted word is followed by a valid result word: its own or an earlier, stalled one.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted word produced no result");

    // With the output empty the input side is never blocked.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output is empty");

endmodule

bind jtag_master_shift_engine_core jmse_checker u_jmse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ bench/jtag_shift_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams and the configuration port of the JTAG shift engine.
// It predicts every result word and compares it with what the engine returns.
module jtag_shift_checker
    import jmse_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    output int          o_pending,
    output logic        o_busy,
    output int          o_mismatches
);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_RESET,
        SEQ_RUN_IDLE,
        SEQ_TMS,
        SEQ_SCAN
    } t_seq;

    // Predicted engine state.
    logic [7:0]  tx_buf [BUFFER_BYTES];
    logic [7:0]  rx_buf [BUFFER_BYTES];
    logic [15:0] tck_half;
    t_seq        seq;
    logic [6:0]  cur_byte;
    logic [3:0]  cur_bit;
    logic [7:0]  shreg;
    logic        tck_low;
    logic [15:0] phase_cnt;
    logic        tdo_sample;
    logic        exit_on_last;
    logic [6:0]  cmd_len;
    logic [9:0]  cmd_bits;
    logic [2:0]  pins_now;

    t_result     result_words[$];
    int          errors = 0;

    initial begin
        o_pending = 0;
        o_busy = 1'b0;
        o_mismatches = 0;
    end

    // Return to idle with all pins low and the clock generator rewound.
    function automatic void close_command();
        seq = SEQ_IDLE;
        pins_now = '0;
        cur_byte = '0;
        cur_bit = '0;
        tck_low = 1'b1;
        phase_cnt = '0;
    endfunction

    function automatic void check_field(string name, int unsigned expected_v,
                                        int unsigned actual_v);
        if (expected_v != actual_v) begin
            $error("%s: expected %0h, got %0h", name, expected_v, actual_v);
            errors++;
        end
    endfunction

    // Apply one input word to the predicted state and return its result word.
    function automatic t_result next_pin_word(t_item w);
        t_result     r;
        logic [2:0]  pins;
        logic [3:0]  nbits;
        logic [15:0] hp;
        logic        tck;
        logic        tms;
        logic        tdi;
        logic        clock_done;
        logic        shifting;
        r = '0;
        pins = pins_now;
        case (w.kind)
            KIND_TICK: begin
                if (seq != SEQ_IDLE) begin
                    hp = (tck_half == 16'd0) ? 16'd1 : tck_half;
                    tms = 1'b0;
                    tdi = 1'b0;
                    nbits = BYTE_BITS;
                    clock_done = 1'b0;
                    shifting = (seq == SEQ_TMS) || (seq == SEQ_SCAN);
                    if (shifting && cur_byte >= cmd_len) begin
                        // Nothing left to shift: complete at once with no clock.
                        close_command();
                        pins = '0;
                        r.done_res = 1'b1;
                    end else begin
                        if (shifting) begin
                            if (cur_byte + 7'd1 == cmd_len && cmd_bits[2:0] != 3'd0) begin
                                nbits = {1'b0, cmd_bits[2:0]};
                            end
                            // A byte is latched, and in a scan its inbound copy cleared, as
                            // its first clock begins.
                            if (tck_low && phase_cnt == 16'd0 && cur_bit == 4'd0) begin
                                shreg = tx_buf[cur_byte];
                                if (seq == SEQ_SCAN) begin
                                    rx_buf[cur_byte] = '0;
                                end
                            end
                        end

                        case (seq)
                            SEQ_RESET: tms = 1'b1;
                            SEQ_TMS:   tms = shreg[0];
                            SEQ_SCAN: begin
                                tdi = shreg[0];
                                if (exit_on_last && cur_bit + 4'd1 == nbits
                                        && cur_byte + 7'd1 == cmd_len) begin
                                    tms = 1'b1;
                                end
                            end
                            default: tms = 1'b0;
                        endcase

                        // TCK stays low one tick longer than it stays high.
                        if (tck_low) begin
                            tck = 1'b0;
                            if (phase_cnt >= hp) begin
                                tck_low = 1'b0;
                                phase_cnt = '0;
                            end else begin
                                phase_cnt = phase_cnt + 16'd1;
                            end
                        end else begin
                            tck = 1'b1;
                            if (phase_cnt == 16'd0) begin
                                tdo_sample = w.tdo_in;
                            end
                            phase_cnt = phase_cnt + 16'd1;
                            if (phase_cnt >= hp) begin
                                clock_done = 1'b1;
                            end
                        end

                        pins = {tdi, tms, tck};
                        pins_now = pins;

                        // End of one full TCK clock.
                        if (clock_done) begin
                            tck_low = 1'b1;
                            phase_cnt = '0;
                            if (seq == SEQ_RESET) begin
                                cur_bit = cur_bit + 4'd1;
                                if (cur_bit >= RESET_CLOCKS) begin
                                    cur_bit = '0;
                                    seq = SEQ_RUN_IDLE;
                                end
                            end else if (seq == SEQ_RUN_IDLE) begin
                                close_command();
                                r.done_res = 1'b1;
                            end else begin
                                if (seq == SEQ_SCAN && cur_bit < BYTE_BITS && tdo_sample) begin
                                    rx_buf[cur_byte][cur_bit[2:0]] = 1'b1;
                                end
                                shreg = shreg >> 1;
                                cur_bit = cur_bit + 4'd1;
                                if (cur_bit >= nbits) begin
                                    cur_bit = '0;
                                    cur_byte = cur_byte + 7'd1;
                                    if (cur_byte >= cmd_len) begin
                                        close_command();
                                        r.done_res = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            KIND_LOAD: begin
                tx_buf[w.byte_index] = w.byte_value;
            end
            KIND_START: begin
                // A start word is dropped while a command runs.
                if (seq == SEQ_IDLE) begin
                    cmd_len = (w.length_bytes > 7'(BUFFER_BYTES)) ? 7'(BUFFER_BYTES)
                                                                    : w.length_bytes;
                    cmd_bits = w.bit_count;
                    cur_byte = '0;
                    cur_bit = '0;
                    tck_low = 1'b1;
                    phase_cnt = '0;
                    exit_on_last = (w.command == CMD_SCAN_EXIT);
                    case (w.command)
                        CMD_TAP_RESET: seq = SEQ_RESET;
                        CMD_TMS_SEQ:   seq = SEQ_TMS;
                        default:       seq = SEQ_SCAN;
                    endcase
                end
            end
            default: begin
                r.read_byte = rx_buf[w.byte_index];
            end
        endcase
        r.tck_out = pins[0];
        r.tms_out = pins[1];
        r.tdi_out = pins[2];
        r.busy_res = (seq != SEQ_IDLE);
        return r;
    endfunction

    // Compare returned words first, then predict the newly accepted word.
    always @(posedge i_clk) begin : watch
        t_result exp_w;
        t_item   in_w;
        if (!i_rst_n) begin
            tck_half = 16'd4;
            shreg = '0;
            tdo_sample = 1'b0;
            exit_on_last = 1'b0;
            cmd_len = '0;
            cmd_bits = '0;
            close_command();
            result_words.delete();
        end else begin
            if (i_cfg_wr_en) begin
                tck_half = i_cfg_wr_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (result_words.size() == 0) begin
                    $error("result word %h arrived with none expected", i_m_tdata);
                    errors++;
                end else begin
                    exp_w = result_words.pop_front();
                    check_field("tck_out", exp_w.tck_out, i_m_tdata[0]);
                    check_field("tms_out", exp_w.tms_out, i_m_tdata[1]);
                    check_field("tdi_out", exp_w.tdi_out, i_m_tdata[2]);
                    check_field("busy_res", exp_w.busy_res, i_m_tdata[3]);
                    check_field("done_res", exp_w.done_res, i_m_tdata[4]);
                    check_field("read_byte", exp_w.read_byte, i_m_tdata[12:5]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                in_w.kind = i_s_tuser;
                in_w.byte_index = i_s_tdata[5:0];
                in_w.byte_value = i_s_tdata[13:6];
                in_w.command = i_s_tdata[15:14];
                in_w.length_bytes = i_s_tdata[22:16];
                in_w.bit_count = i_s_tdata[32:23];
                in_w.tdo_in = i_s_tdata[33];
                result_words.push_back(next_pin_word(in_w));
            end
        end
        o_pending <= result_words.size();
        o_busy <= (seq != SEQ_IDLE);
        o_mismatches <= errors;
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import jmse_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;

    int          pending;
    logic        busy;
    int          mismatches;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    int          words_sent = 0;
    int          starts [4] = '{0, 0, 0, 0};

    jtag_master_shift_engine_core #(
        .BUFFER_BYTES(64)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    jtag_shift_checker #(
        .BUFFER_BYTES(64)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_pending     (pending),
        .o_busy        (busy),
        .o_mismatches  (mismatches)
    );

    always #1 i_clk = ~i_clk;

    // Random backpressure on the result stream.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // End the run if no word moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Every field random; callers override what a word needs.
    function automatic t_item rand_item();
        t_item w;
        w.kind = 2'($urandom_range(0, 3));
        w.byte_index = 6'($urandom_range(0, 63));
        w.byte_value = 8'($urandom_range(0, 255));
        w.command = 2'($urandom_range(0, 3));
        w.length_bytes = 7'($urandom_range(0, 127));
        w.bit_count = 10'($urandom_range(0, 1023));
        w.tdo_in = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Offer one word after a random gap and hold it until accepted.
    task automatic send_word(input t_item w);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, w.tdo_in, w.bit_count, w.length_bytes, w.command,
                         w.byte_value, w.byte_index};
        s_axis_tuser <= w.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        if (w.kind == KIND_START) begin
            starts[w.command]++;
        end
    endtask

    task automatic load_byte(input logic [5:0] idx, input logic [7:0] val);
        t_item w;
        w = rand_item();
        w.kind = KIND_LOAD;
        w.byte_index = idx;
        w.byte_value = val;
        send_word(w);
    endtask

    task automatic read_byte(input logic [5:0] idx);
        t_item w;
        w = rand_item();
        w.kind = KIND_READ;
        w.byte_index = idx;
        send_word(w);
    endtask

    task automatic start_word(input logic [1:0] cmd, input logic [6:0] len,
                              input logic [9:0] bits);
        t_item w;
        w = rand_item();
        w.kind = KIND_START;
        w.command = cmd;
        w.length_bytes = len;
        w.bit_count = bits;
        send_word(w);
    endtask

    // Tick with random TDO until the checker predicts an idle engine; mess_pct of the
    // words are random words of any kind instead.
    task automatic tick_until_idle(input int mess_pct);
        t_item w;
        do begin
            w = rand_item();
            if ($urandom_range(0, 99) >= mess_pct) begin
                w.kind = KIND_TICK;
            end
            send_word(w);
        end while (busy);
    endtask

    task automatic run_command(input logic [1:0] cmd, input logic [6:0] len,
                               input logic [9:0] bits, input int mess_pct);
        start_word(cmd, len, bits);
        tick_until_idle(mess_pct);
    endtask

    // Stop sending until every predicted word has come back.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write the register only with the engine idle and the result stream empty.
    task automatic set_half_period(input logic [15:0] hp);
        tick_until_idle(0);
        wait_results();
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= hp;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] phase_hp [4];
        int          phase_send_idle [4];
        int          phase_stall [4];
        int          pick;
        logic [6:0]  len;

        phase_hp = '{16'd1, 16'd2, 16'd0, 16'd3};
        phase_send_idle = '{0, 56, 0, 28};
        phase_stall = '{0, 0, 56, 28};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the outbound buffer and scan all of it, so that every inbound
        // byte holds data before any read. This runs at the reset half period.
        for (int i = 0; i < 64; i++) begin
            load_byte(6'(i), (i == 0) ? 8'h00 : (i == 63) ? 8'hFF
                                      : 8'($urandom_range(0, 255)));
        end
        run_command(CMD_SCAN_EXIT, 7'd64, 10'd512, 0);
        read_byte(6'd0);
        read_byte(6'd63);

        // Directed commands.
        run_command(CMD_TAP_RESET, 7'($urandom_range(0, 127)), 10'd0, 0);
        tick_until_idle(0);
        set_half_period(16'd1);
        run_command(CMD_TMS_SEQ, 7'd1, 10'd1, 0);
        load_byte(6'd0, 8'hA5);
        load_byte(6'd1, 8'h3C);

        // Start, load and read words that arrive while a scan runs.
        start_word(CMD_SCAN, 7'd2, 10'd9);
        start_word(CMD_TMS_SEQ, 7'd1, 10'd3);
        load_byte(6'd1, 8'hC3);
        read_byte(6'd0);
        tick_until_idle(0);
        read_byte(6'd0);
        read_byte(6'd1);

        // Zero length, then a length beyond the buffer.
        run_command(CMD_SCAN, 7'd0, 10'd5, 0);
        run_command(CMD_SCAN_EXIT, 7'd127, 10'd1023, 0);
        read_byte(6'd63);

        // Half period of zero, then the largest one.
        set_half_period(16'd0);
        run_command(CMD_TMS_SEQ, 7'd1, 10'd8, 0);
        run_command(CMD_SCAN_EXIT, 7'd1, 10'd3, 0);
        set_half_period(16'hFFFF);
        run_command(CMD_TMS_SEQ, 7'd1, 10'd1, 0);

        // Random command sequences under each idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            set_half_period(phase_hp[ph]);
            send_idle_pct = phase_send_idle[ph];
            stall_pct <= phase_stall[ph];
            repeat (25) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    send_word(rand_item());
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        load_byte(6'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 5) begin
                        len = 7'd0;
                    end else if (pick < 10) begin
                        len = 7'($urandom_range(0, 127));
                    end else begin
                        len = 7'($urandom_range(1, 3));
                    end
                    run_command(2'($urandom_range(0, 3)), len,
                                10'($urandom_range(0, 1023)), 8);
                    repeat ($urandom_range(1, 2)) begin
                        read_byte(6'($urandom_range(0, 3)));
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        wait_results();
                    end
                end
            end
        end

        wait_results();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d words; starts issued: reset %0d, TMS %0d, scan %0d, scan-exit %0d.",
                 words_sent, starts[CMD_TAP_RESET], starts[CMD_TMS_SEQ],
                 starts[CMD_SCAN], starts[CMD_SCAN_EXIT]);
        $display("Half periods 0, 1, 2, 3, 4 and 65535 were used, with sender gaps and stalls.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/jmse_pkg.sv
design/jmse_engine.sv
design/jtag_master_shift_engine_core.sv
design/jmse_checker.sv
bench/jtag_shift_checker.sv
bench/tb.sv
